/* src/epdm_pkg.sv */
package epdm_pkg;

    // Number of sensor channels with state in the sensor memory.
    localparam int SENSORS = 8;
    localparam int SENS_AW = (SENSORS > 1) ? $clog2(SENSORS) : 1;

    // Input opcodes.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_ECHO  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_MEASURED = 2'd0;
    localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
    localparam logic [1:0] STATUS_BAD_ID   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WRAP_AT_TOP  = 2'd0;
    localparam logic [1:0] CFG_COUNTER_TOP  = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_MS   = 2'd2;
    localparam logic [1:0] CFG_SENSOR_COUNT = 2'd3;

    localparam logic [15:0] FULL_TOP     = 16'hFFFF;
    localparam logic [6:0]  TICKS_PER_CM = 7'd116;
    localparam logic [8:0]  MAX_CM       = 9'd400;

    // floor(2^23 / 116); the quotient estimate is low by at most one.
    localparam logic [16:0] CM_RECIP = 17'd72315;
    localparam int          CM_SHIFT = 23;

    typedef enum logic [1:0] {
        PHASE_IDLE,
        PHASE_RISE,
        PHASE_DONE
    } phase_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_START_WR,
        CS_WALK,
        CS_CHECK_RD,
        CS_CHECK,
        CS_DIV,
        CS_EMIT
    } ctl_state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  sensor_id;
        logic [7:0]  echo_levels;
        logic [15:0] timer_count;
    } in_item_t;

    typedef struct packed {
        logic [2:0] result_sensor;
        logic [8:0] distance_cm;
        logic [1:0] status;
    } result_t;

    typedef struct packed {
        logic        last_level;
        phase_t      phase;
        logic [15:0] rise;
        logic [15:0] fall;
    } entry_t;

    typedef struct packed {
        logic               en;
        logic [SENS_AW-1:0] addr;
        entry_t             data;
    } ram_wr_t;

    typedef struct packed {
        logic        start;
        logic [15:0] rise;
        logic [15:0] fall;
    } div_req_t;

    typedef struct packed {
        logic       done;
        logic [8:0] dist_cm;
    } div_rsp_t;

endpackage

/* src/epdm_sensor_ram.sv */
module epdm_sensor_ram
    import epdm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  ram_wr_t            wr,
    input  logic               rd_en,
    input  logic [SENS_AW-1:0] rd_addr,
    output entry_t             rd_data
);

    entry_t             mem [SENSORS];
    entry_t             rd_reg;
    logic               rd_valid_reg;
    logic [SENSORS-1:0] valid_reg;
    logic [SENSORS-1:0] valid_next;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    // An entry never written reads as idle with a low last level.
    always_comb begin
        valid_next = valid_reg;
        if (wr.en) begin
            valid_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_comb begin
        rd_data = rd_reg;
        if (!rd_valid_reg) begin
            rd_data.last_level = 1'b0;
            rd_data.phase      = PHASE_IDLE;
        end
    end

endmodule

/* src/epdm_range_div.sv */
module epdm_range_div
    import epdm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wrap_at_top,
    input  logic [15:0] counter_top,
    input  div_req_t    req,
    output div_rsp_t    rsp
);

    logic [15:0] top;
    logic [15:0] ticks;
    logic [15:0] ticks0_reg;
    logic [15:0] ticks1_reg;
    logic [32:0] prod_reg;
    logic [9:0]  q0;
    logic [16:0] back;
    logic [15:0] rem;
    logic [9:0]  quot;
    logic [8:0]  dist_next;
    logic [8:0]  dist_reg;
    logic        v0_reg;
    logic        v1_reg;
    logic        v2_reg;

    // Pulse width in timer ticks; a wrapped pulse spans the counter top.
    always_comb begin
        top = wrap_at_top ? counter_top : FULL_TOP;
        if (req.fall >= req.rise) begin
            ticks = req.fall - req.rise;
        end else begin
            ticks = top - req.rise + req.fall + 16'd1;
        end
    end

    // Quotient estimate by reciprocal, then a single correction step.
    always_comb begin
        q0   = prod_reg[CM_SHIFT +: 10];
        back = q0 * TICKS_PER_CM;
        rem  = ticks1_reg - back[15:0];
        if (rem >= 16'(TICKS_PER_CM)) begin
            quot = q0 + 10'd1;
        end else begin
            quot = q0;
        end
        if (quot > 10'(MAX_CM)) begin
            dist_next = MAX_CM;
        end else begin
            dist_next = quot[8:0];
        end
    end

    always_ff @(posedge aclk) begin
        ticks0_reg <= ticks;
        prod_reg   <= ticks0_reg * CM_RECIP;
        ticks1_reg <= ticks0_reg;
        dist_reg   <= dist_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v0_reg <= req.start;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    assign rsp.done    = v2_reg;
    assign rsp.dist_cm = dist_reg;

endmodule

/* src/echo_pulse_distance_meter.sv */
// A start writes its sensor's entry back from the start-write state; a bad id and a timeout
// go straight to the emit state. An echo walks the n sensors in use one per memory cycle, then
// reads the armed sensor's entry if measuring, and with a finished pulse runs the divider
// and emits its result. The input takes one transaction at a time; a result waits in the
// emit state while the output register still holds an untaken result and m_ready is low.
// Reset (synchronous, aresetn low): idle, not measuring, registers at defaults, entries idle.
module echo_pulse_distance_meter
    import epdm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,

    output logic       m_valid,
    input  logic       m_ready,
    output result_t    m_data,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers.
    logic        wrap_reg,    wrap_next;
    logic [15:0] top_reg,     top_next;
    logic [9:0]  timeout_reg, timeout_next;
    logic [3:0]  count_reg,   count_next;

    // Sequencer and measurement state.
    ctl_state_t         state_reg,     state_next;
    logic               measuring_reg, measuring_next;
    logic [2:0]         armed_reg,     armed_next;
    logic [9:0]         elapsed_reg,   elapsed_next;
    logic [SENS_AW-1:0] idx_reg,       idx_next;
    in_item_t           item_reg,      item_next;
    result_t            res_reg,       res_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_data_reg,  out_data_next;

    logic [3:0]         n_use;
    logic               cur_level;
    entry_t             upd;

    ram_wr_t            wr;
    logic               rd_en;
    logic [SENS_AW-1:0] rd_addr;
    entry_t             rd_data;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // The per-sensor phase, level and stamps live in one small memory.
    epdm_sensor_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Pulse width and the division by 116 run in a three-stage pipeline.
    epdm_range_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wrap_at_top (wrap_reg),
        .counter_top (top_reg),
        .req         (div_req),
        .rsp         (div_rsp)
    );

    // Always ready; the user writes only while the block is idle, which it does not enforce.
    assign cfg_ready = 1'b1;

    always_comb begin
        wrap_next    = wrap_reg;
        top_next     = top_reg;
        timeout_next = timeout_reg;
        count_next   = count_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_WRAP_AT_TOP:  wrap_next    = cfg_data[0];
                CFG_COUNTER_TOP:  top_next     = cfg_data;
                CFG_TIMEOUT_MS:   timeout_next = cfg_data[9:0];
                CFG_SENSOR_COUNT: count_next   = cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Sensors in use never exceed the number of channels with state.
    assign n_use = (count_reg < 4'(SENSORS)) ? count_reg : 4'(SENSORS);

    // Edge detection for the sensor being walked: a rise is recorded only in the
    // idle phase, a fall only after a rise; any change updates the stored level.
    always_comb begin
        cur_level = item_reg.echo_levels[idx_reg];
        upd       = rd_data;
        if (cur_level != rd_data.last_level) begin
            upd.last_level = cur_level;
            if (cur_level && (rd_data.phase == PHASE_IDLE)) begin
                upd.rise  = item_reg.timer_count;
                upd.phase = PHASE_RISE;
            end else if (!cur_level && (rd_data.phase == PHASE_RISE)) begin
                upd.fall  = item_reg.timer_count;
                upd.phase = PHASE_DONE;
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        measuring_next = measuring_reg;
        armed_next     = armed_reg;
        elapsed_next   = elapsed_reg;
        idx_next       = idx_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        s_ready        = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr             = '0;
        div_req        = '0;

        case (state_reg)
            CS_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next = s_data;
                    case (s_data.opcode)
                        OP_START: begin
                            // A bad id answers at once, busy or not; a valid start
                            // while busy is dropped.
                            if ({1'b0, s_data.sensor_id} >= n_use) begin
                                res_next.result_sensor = s_data.sensor_id;
                                res_next.distance_cm   = '0;
                                res_next.status        = STATUS_BAD_ID;
                                state_next             = CS_EMIT;
                            end else if (!measuring_reg) begin
                                measuring_next = 1'b1;
                                armed_next     = s_data.sensor_id;
                                elapsed_next   = '0;
                                rd_en          = 1'b1;
                                rd_addr        = s_data.sensor_id[SENS_AW-1:0];
                                state_next     = CS_START_WR;
                            end
                        end
                        OP_ECHO: begin
                            if (n_use != 4'd0) begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = CS_WALK;
                            end else begin
                                state_next = CS_CHECK_RD;
                            end
                        end
                        OP_TICK: begin
                            // The timeout result comes on tick number timeout_ms + 1.
                            if (measuring_reg) begin
                                if (elapsed_reg >= timeout_reg) begin
                                    measuring_next         = 1'b0;
                                    res_next.result_sensor = armed_reg;
                                    res_next.distance_cm   = '0;
                                    res_next.status        = STATUS_TIMEOUT;
                                    state_next             = CS_EMIT;
                                end else begin
                                    elapsed_next = elapsed_reg + 10'd1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            CS_START_WR: begin
                // Arming clears only the phase; level and stamps are kept.
                wr.en         = 1'b1;
                wr.addr       = armed_reg[SENS_AW-1:0];
                wr.data       = rd_data;
                wr.data.phase = PHASE_IDLE;
                state_next    = CS_IDLE;
            end

            CS_WALK: begin
                // Write back sensor idx while reading sensor idx + 1; the two never
                // address the same entry, so no forwarding is needed.
                wr.en   = 1'b1;
                wr.addr = idx_reg;
                wr.data = upd;
                if ((4'(idx_reg) + 4'd1) < n_use) begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end else begin
                    state_next = CS_CHECK_RD;
                end
            end

            CS_CHECK_RD: begin
                // The last walk write has landed, so this read sees fresh data.
                if (measuring_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = armed_reg[SENS_AW-1:0];
                    state_next = CS_CHECK;
                end else begin
                    state_next = CS_IDLE;
                end
            end

            CS_CHECK: begin
                if (rd_data.phase == PHASE_DONE) begin
                    div_req.start  = 1'b1;
                    div_req.rise   = rd_data.rise;
                    div_req.fall   = rd_data.fall;
                    measuring_next = 1'b0;
                    state_next     = CS_DIV;
                end else begin
                    state_next = CS_IDLE;
                end
            end

            CS_DIV: begin
                if (div_rsp.done) begin
                    res_next.result_sensor = armed_reg;
                    res_next.distance_cm   = div_rsp.dist_cm;
                    res_next.status        = STATUS_MEASURED;
                    state_next             = CS_EMIT;
                end
            end

            CS_EMIT: begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = CS_IDLE;
                end
            end

            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= CS_IDLE;
            measuring_reg <= 1'b0;
            armed_reg     <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
            wrap_reg      <= 1'b0;
            top_reg       <= 16'hFFFF;
            timeout_reg   <= 10'd30;
            count_reg     <= 4'd0;
        end else begin
            state_reg     <= state_next;
            measuring_reg <= measuring_next;
            armed_reg     <= armed_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
            wrap_reg      <= wrap_next;
            top_reg       <= top_next;
            timeout_reg   <= timeout_next;
            count_reg     <= count_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        item_reg     <= item_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

/* src/epdm_checker.sv */
module epdm_checker
    import epdm_pkg::*;
(
    input logic    aclk,
    input logic    aresetn,
    input logic    m_valid,
    input logic    m_ready,
    input result_t m_data
);

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result transaction holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // Only defined status codes and clamped distances leave the block.
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.distance_cm <= MAX_CM) &&
                    (m_data.status == STATUS_MEASURED || m_data.status == STATUS_TIMEOUT ||
                     m_data.status == STATUS_BAD_ID))
        else $error("result out of range");

    // Error results carry a zero distance.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != STATUS_MEASURED) |-> (m_data.distance_cm == 9'd0))
        else $error("error result with nonzero distance");

endmodule

bind echo_pulse_distance_meter epdm_checker u_epdm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* test/testbench.sv */
module testbench;
    import epdm_pkg::*;

    // Opcode 3 has no meaning for the block and must be dropped without a result.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Settling for well over the time an echo with a result takes covers an echo
    // that is still being worked on with no result owed.
    localparam int SETTLE_CYCLES = 40;
    // The longest quiet stretch in a correct run is the long receiver hold-off.
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRINT_LIMIT = 100;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;

    logic m_valid;
    logic m_ready = 1'b0;
    result_t m_data;

    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = CFG_WRAP_AT_TOP;
    logic [15:0] cfg_data = '0;

    echo_pulse_distance_meter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Shared bookkeeping between the stimulus, the driver and the two monitors.
    in_item_t pending_items[$];
    result_t expected_results[$];
    int unsigned queued_count = 0;
    int unsigned accepted_count = 0;
    int unsigned mismatch_count = 0;
    bit item_taken = 1'b0;
    bit no_idle = 1'b0;
    int unsigned long_hold_asked = 0;

    // Shadow of the configuration registers, updated when a write transaction
    // completes. The values at declaration are the reset values.
    logic        ranging_wrap = 1'b0;
    logic [15:0] ranging_top = 16'hFFFF;
    logic [9:0]  ranging_timeout = 10'd30;
    logic [3:0]  ranging_count = 4'd0;

    // Shadow of the measurement state. Stamps are only ever read after the
    // sensor has reached the done phase, so their start value never matters.
    logic        meas_busy = 1'b0;
    logic [2:0]  meas_sensor = '0;
    logic [9:0]  meas_elapsed = '0;
    phase_t      sens_phase[SENSORS];
    logic [15:0] sens_rise[SENSORS];
    logic [15:0] sens_fall[SENSORS];
    logic        sens_level[SENSORS];

    initial begin
        for (int i = 0; i < SENSORS; i++) begin
            sens_phase[i] = PHASE_IDLE;
            sens_rise[i] = '0;
            sens_fall[i] = '0;
            sens_level[i] = 1'b0;
        end
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("ERROR: %s", msg);
        end
    endtask

    // Works out what one accepted input transaction does to the measurement
    // state and queues the result it owes, if any.
    task automatic predict_ranging(input in_item_t it);
        int unsigned in_use;
        int unsigned dist_cm;
        logic [15:0] top;
        logic [15:0] ticks;
        logic cur;
        result_t res;
        in_use = (ranging_count < SENSORS) ? ranging_count : SENSORS;
        case (it.opcode)
            OP_START: begin
                // A bad id is answered at once even in the middle of a measurement.
                if (it.sensor_id >= in_use) begin
                    res.result_sensor = it.sensor_id;
                    res.distance_cm = '0;
                    res.status = STATUS_BAD_ID;
                    expected_results.push_back(res);
                end else if (!meas_busy) begin
                    meas_busy = 1'b1;
                    meas_sensor = it.sensor_id;
                    meas_elapsed = '0;
                    sens_phase[it.sensor_id] = PHASE_IDLE;
                end
            end
            OP_ECHO: begin
                for (int i = 0; i < in_use; i++) begin
                    cur = it.echo_levels[i];
                    if (cur != sens_level[i]) begin
                        sens_level[i] = cur;
                        if (cur && sens_phase[i] == PHASE_IDLE) begin
                            sens_rise[i] = it.timer_count;
                            sens_phase[i] = PHASE_RISE;
                        end else if (!cur && sens_phase[i] == PHASE_RISE) begin
                            sens_fall[i] = it.timer_count;
                            sens_phase[i] = PHASE_DONE;
                        end
                    end
                end
                if (meas_busy && sens_phase[meas_sensor] == PHASE_DONE) begin
                    // A fall stamp below the rise stamp means the timer wrapped.
                    top = ranging_wrap ? ranging_top : FULL_TOP;
                    if (sens_fall[meas_sensor] >= sens_rise[meas_sensor]) begin
                        ticks = sens_fall[meas_sensor] - sens_rise[meas_sensor];
                    end else begin
                        ticks = top - sens_rise[meas_sensor] + sens_fall[meas_sensor] + 16'd1;
                    end
                    dist_cm = ticks / TICKS_PER_CM;
                    if (dist_cm > MAX_CM) begin
                        dist_cm = MAX_CM;
                    end
                    meas_busy = 1'b0;
                    res.result_sensor = meas_sensor;
                    res.distance_cm = 9'(dist_cm);
                    res.status = STATUS_MEASURED;
                    expected_results.push_back(res);
                end
            end
            OP_TICK: begin
                if (meas_busy) begin
                    if (meas_elapsed >= ranging_timeout) begin
                        meas_busy = 1'b0;
                        res.result_sensor = meas_sensor;
                        res.distance_cm = '0;
                        res.status = STATUS_TIMEOUT;
                        expected_results.push_back(res);
                    end else begin
                        meas_elapsed = meas_elapsed + 10'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    // Input side: every transaction that completes at this edge goes through
    // the predictor. The flag tells the driver at the next falling edge.
    always @(posedge aclk) begin
        item_taken = (aresetn === 1'b1) && s_valid && (s_ready === 1'b1);
        if (item_taken) begin
            predict_ranging(s_data);
            accepted_count++;
        end
    end

    // Output side: each result transaction is held against the oldest
    // expectation, field by field.
    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready) begin
            if (expected_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result sensor %0d distance %0d status %0d",
                    m_data.result_sensor, m_data.distance_cm, m_data.status));
            end else begin
                want = expected_results.pop_front();
                if (m_data.result_sensor !== want.result_sensor) begin
                    flag_mismatch($sformatf("result_sensor %0d, expected %0d",
                        m_data.result_sensor, want.result_sensor));
                end
                if (m_data.distance_cm !== want.distance_cm) begin
                    flag_mismatch($sformatf("distance_cm %0d, expected %0d (sensor %0d)",
                        m_data.distance_cm, want.distance_cm, want.result_sensor));
                end
                if (m_data.status !== want.status) begin
                    flag_mismatch($sformatf("status %0d, expected %0d (sensor %0d)",
                        m_data.status, want.status, want.result_sensor));
                end
            end
        end
    end

    // Driver: offers the pending items one at a time. Once valid is raised it
    // holds with the same payload until the transaction completes. Between
    // items it sometimes idles for a random burst.
    always @(negedge aclk) begin : drive_items
        int unsigned gap_left;
        bit next_valid;
        if (aresetn !== 1'b1) begin
            gap_left = 0;
            s_valid <= 1'b0;
        end else if (!s_valid || item_taken) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_items.size() > 0) begin
                if (!no_idle && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(1, 15) - 1;
                end else begin
                    s_data <= pending_items.pop_front();
                    next_valid = 1'b1;
                end
            end
            s_valid <= next_valid;
        end
    end

    // Receiver: ready drops in random bursts, and once on request for a long
    // hold-off so that a result backs up and the block stalls its input.
    always @(negedge aclk) begin : accept_results
        int unsigned hold_left;
        int unsigned hold_served;
        if (aresetn !== 1'b1) begin
            hold_left = 0;
            hold_served = 0;
            m_ready <= 1'b0;
        end else if (hold_served != long_hold_asked) begin
            hold_served = long_hold_asked;
            hold_left = LONG_HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(1, 15) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: a long run of cycles with no transaction on any channel means
    // the block has hung.
    always @(posedge aclk) begin : watchdog
        int unsigned quiet_cycles;
        if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)
                || (cfg_valid && cfg_ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_item(input logic [1:0] op, input logic [2:0] id,
                              input logic [7:0] levels, input logic [15:0] stamp);
        in_item_t it;
        it.opcode = op;
        it.sensor_id = id;
        it.echo_levels = levels;
        it.timer_count = stamp;
        pending_items.push_back(it);
        queued_count++;
    endtask

    // Blocks until every queued item has been taken and every result owed has
    // come back.
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (accepted_count != queued_count || expected_results.size() != 0);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (cfg_ready !== 1'b1);
        case (idx)
            CFG_WRAP_AT_TOP:  ranging_wrap = value[0];
            CFG_COUNTER_TOP:  ranging_top = value;
            CFG_TIMEOUT_MS:   ranging_timeout = value[9:0];
            CFG_SENSOR_COUNT: ranging_count = value[3:0];
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // The sender pauses here until the block has delivered everything, lets
    // the last echo walk finish, and only then touches the registers.
    task automatic reconfigure(input logic wrap, input logic [15:0] top,
                               input logic [9:0] timeout, input logic [3:0] count);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_register(CFG_WRAP_AT_TOP, 16'(wrap));
        write_register(CFG_COUNTER_TOP, top);
        write_register(CFG_TIMEOUT_MS, 16'(timeout));
        write_register(CFG_SENSOR_COUNT, 16'(count));
    endtask

    // Random traffic is mostly complete measurements: arm a sensor, pull its
    // echo low, raise it, maybe tick a few milliseconds, drop it again. The
    // other sensors' levels are random throughout, so they rise and fall on
    // their own. The rest is noise on all fields, including the unused opcode.
    task automatic queue_random_traffic(input int unsigned n_items);
        int unsigned queued;
        int unsigned in_use;
        int unsigned tick_count;
        logic [2:0] id;
        logic [7:0] lv;
        logic [15:0] rise;
        logic [15:0] fall;
        queued = 0;
        in_use = (ranging_count < SENSORS) ? ranging_count : SENSORS;
        while (queued < n_items) begin
            if ($urandom_range(0, 9) < 8) begin
                if (in_use > 0 && $urandom_range(0, 9) != 0) begin
                    id = 3'($urandom_range(0, in_use - 1));
                end else begin
                    id = 3'($urandom);
                end
                queue_item(OP_START, id, 8'($urandom), 16'($urandom));
                lv = 8'($urandom);
                lv[id] = 1'b0;
                queue_item(OP_ECHO, 3'($urandom), lv, 16'($urandom));
                rise = 16'($urandom);
                lv = 8'($urandom);
                lv[id] = 1'b1;
                queue_item(OP_ECHO, 3'($urandom), lv, rise);
                tick_count = $urandom_range(0, 3);
                for (int t = 0; t < tick_count; t++) begin
                    queue_item(OP_TICK, 3'($urandom), 8'($urandom), 16'($urandom));
                end
                // Half the pulses are at most 47000 ticks long, mostly in range; the other
                // half use any stamp, which wraps or clamps often.
                if ($urandom_range(0, 1) == 1) begin
                    fall = rise + 16'($urandom_range(0, 47000));
                end else begin
                    fall = 16'($urandom);
                end
                lv = 8'($urandom);
                lv[id] = 1'b0;
                queue_item(OP_ECHO, 3'($urandom), lv, fall);
                queued += 4 + tick_count;
            end else begin
                queue_item(2'($urandom), 3'($urandom), 8'($urandom), 16'($urandom));
                queued++;
            end
        end
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings have no sensors in use: every start is a bad id, and
        // echoes, ticks and the unused opcode leave no trace.
        queue_item(OP_START, 3'd0, 8'h00, 16'h0000);
        queue_item(OP_START, 3'd7, 8'hFF, 16'hFFFF);
        queue_item(OP_TICK, 3'd0, 8'h00, 16'h0000);
        queue_item(OP_ECHO, 3'd0, 8'hFF, 16'hFFFF);
        queue_item(OP_UNUSED, 3'd7, 8'hFF, 16'hFFFF);
        queue_item(OP_ECHO, 3'd0, 8'h00, 16'h0000);

        // All eight sensors: a plain pulse, a start while busy, a pulse across
        // the full counter wrap, a pulse long enough to clamp, and a timeout
        // followed by a tick with nothing armed.
        reconfigure(1'b0, 16'hFFFF, 10'd3, 4'd8);
        queue_item(OP_START, 3'd0, 8'h00, 16'h0000);
        queue_item(OP_START, 3'd5, 8'h00, 16'h0000);
        queue_item(OP_ECHO, 3'd0, 8'h01, 16'd100);
        queue_item(OP_ECHO, 3'd0, 8'h00, 16'd5900);
        queue_item(OP_START, 3'd7, 8'h00, 16'h0000);
        queue_item(OP_ECHO, 3'd0, 8'h80, 16'd65500);
        queue_item(OP_ECHO, 3'd0, 8'h00, 16'd200);
        queue_item(OP_START, 3'd3, 8'h00, 16'h0000);
        queue_item(OP_ECHO, 3'd0, 8'h08, 16'h0000);
        queue_item(OP_ECHO, 3'd0, 8'h00, 16'hFFFF);
        queue_item(OP_START, 3'd2, 8'h00, 16'h0000);
        repeat (4) queue_item(OP_TICK, 3'd0, 8'h00, 16'h0000);
        queue_item(OP_TICK, 3'd0, 8'h00, 16'h0000);

        // Five sensors and a short counter top: a bad id, a pulse that wraps
        // at the programmed top, and a timeout on the second tick.
        reconfigure(1'b1, 16'd1000, 10'd1, 4'd5);
        queue_item(OP_START, 3'd6, 8'h00, 16'h0000);
        queue_item(OP_START, 3'd1, 8'h00, 16'h0000);
        queue_item(OP_ECHO, 3'd0, 8'h02, 16'd900);
        queue_item(OP_ECHO, 3'd0, 8'h00, 16'd50);
        queue_item(OP_START, 3'd4, 8'h00, 16'h0000);
        repeat (2) queue_item(OP_TICK, 3'd0, 8'h00, 16'h0000);

        reconfigure(1'b0, 16'hFFFF, 10'd1000, 4'd8);
        queue_random_traffic(240);

        // A short timeout makes many measurements end on a tick.
        reconfigure(1'b1, 16'd40000, 10'd2, 4'd8);
        queue_random_traffic(240);

        // Only three sensors, so bad ids are frequent. The receiver holds off
        // for a long stretch while the sender keeps offering items.
        reconfigure(1'b1, 16'd0, 10'd5, 4'd3);
        long_hold_asked++;
        queue_random_traffic(240);

        // A zero timeout gives up on the very first tick.
        reconfigure(1'b1, 16'hFFFF, 10'd0, 4'd1);
        queue_random_traffic(240);

        // A count above the number of sensors is clipped to eight.
        reconfigure(1'b0, 16'd300, 10'd1000, 4'd15);
        queue_random_traffic(240);

        // Closing stretch runs at full rate with no idling on either side.
        reconfigure(1'b1, 16'hFFFF, 10'd10, 4'd8);
        no_idle = 1'b1;
        queue_random_traffic(240);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
